// File: rtl/core/mdrp_pkg.sv
// Shared constants, codes and types of the duty ramp profile generator.
package mdrp_pkg;

	// Fixed-point layout of the duty accumulator
	localparam int FRAC_BITS = 16;
	localparam int DUTY_BITS = 16;
	localparam int ACC_W     = DUTY_BITS + FRAC_BITS + 1;
	localparam int INC_W     = DUTY_BITS + FRAC_BITS;
	localparam int ACC_CNT_W = $clog2(ACC_W);
	localparam int DIV_CNT_W = $clog2(INC_W);

	// Field and register widths
	localparam int CFG_W     = 16;
	localparam int SECS_W    = 15;
	localparam int DUTY_W    = 16;
	localparam int PHASE_W   = 3;
	localparam int OP_W      = 3;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 5;
	localparam int REG_IDX_W = 3;
	localparam int INC_IDX_W = 2;

	localparam logic [DUTY_BITS-1:0] DUTY_MAX          = '1;
	localparam logic [SECS_W-1:0]    SECS_MAX          = '1;
	localparam logic [CFG_W-1:0]     CALL_PERIOD_RESET = CFG_W'(200);

	// Ramp phases
	localparam logic [PHASE_W-1:0] PH_WAIT         = 3'd0;
	localparam logic [PHASE_W-1:0] PH_UP           = 3'd1;
	localparam logic [PHASE_W-1:0] PH_STEADY       = 3'd2;
	localparam logic [PHASE_W-1:0] PH_DOWN         = 3'd3;
	localparam logic [PHASE_W-1:0] PH_OVER         = 3'd4;
	localparam logic [PHASE_W-1:0] PH_EOS_DOWN     = 3'd5;
	localparam logic [PHASE_W-1:0] PH_BOS_UP       = 3'd6;
	localparam logic [PHASE_W-1:0] PH_CONFIRM_STOP = 3'd7;

	// Command codes
	localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
	localparam logic [OP_W-1:0] OP_START  = 3'd1;
	localparam logic [OP_W-1:0] OP_STOP   = 3'd2;
	localparam logic [OP_W-1:0] OP_EOS    = 3'd3;
	localparam logic [OP_W-1:0] OP_BOS    = 3'd4;

	// Increment table slots
	localparam logic [INC_IDX_W-1:0] INC_UP   = 2'd0;
	localparam logic [INC_IDX_W-1:0] INC_DOWN = 2'd1;
	localparam logic [INC_IDX_W-1:0] INC_EOS  = 2'd2;
	localparam logic [INC_IDX_W-1:0] INC_BOS  = 2'd3;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_TARGET   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PERIOD   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_RAMP_UP  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_RAMP_DN  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BOS_UP   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_EOS_DN   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_STEADY   = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_FOREVER  = 3'd7;

	typedef struct packed {
		logic [CFG_W-1:0]  target_duty;
		logic [CFG_W-1:0]  call_period_ms;
		logic [CFG_W-1:0]  ramp_up_ms;
		logic [CFG_W-1:0]  ramp_down_ms;
		logic [CFG_W-1:0]  bos_up_ms;
		logic [CFG_W-1:0]  eos_down_ms;
		logic [SECS_W-1:0] steady_seconds;
		logic              hold_steady;
	} cfg_t;

	// Command to the serial accumulator
	typedef struct packed {
		logic start;
		logic sub;
		logic clear;
	} alu_ctl_t;

endpackage

// File: rtl/core/mdrp_if.sv
// Command and result channels of the duty ramp profile generator.
interface mdrp_cmd_if;
	logic                       valid;
	logic                       ready;
	logic [mdrp_pkg::OP_W-1:0]  operation;
	logic                       second_passed;

	modport source (output valid, operation, second_passed, input ready);
	modport sink (input valid, operation, second_passed, output ready);
endinterface

interface mdrp_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [mdrp_pkg::DUTY_W-1:0]   duty;
	logic [mdrp_pkg::PHASE_W-1:0]  phase;
	logic                          timer_restart;

	modport source (output valid, duty, phase, timer_restart, input ready);
	modport sink (input valid, duty, phase, timer_restart, output ready);
endinterface

// File: rtl/core/motor_duty_ramp_profile.sv
// Top level of the trapezoidal PWM duty ramp profile generator.
//
// One command beat in, one result beat out, one command at a time. A tick in a ramp
// phase runs the bit-serial accumulator, which walks the 33-bit fine duty one bit per
// cycle; a tick in any other phase and the stop, end-of-stroke and beginning-of-stroke
// commands go from decode straight to the finish state. Start runs the radix-2 divider
// for eight divisions, a step count and an increment for each of the four ramps. A
// result may wait in the output register while the next command is accepted; a held
// output adds its stall cycles to the following command. Configuration is written
// over APB with pready always high; registers sit at byte offsets 4*index.
module motor_duty_ramp_profile (
	input  logic                          clk,
	input  logic                          arst_n,
	mdrp_cmd_if.sink                      cmd,
	mdrp_rsp_if.source                    rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mdrp_pkg::ADDR_W-1:0]   paddr,
	input  logic [mdrp_pkg::DATA_W-1:0]   pwdata,
	output logic [mdrp_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int IW = mdrp_pkg::INC_W;
	localparam int CW = mdrp_pkg::CFG_W;
	localparam int DB = mdrp_pkg::DUTY_BITS;
	localparam int FB = mdrp_pkg::FRAC_BITS;
	localparam int AW = mdrp_pkg::ACC_W;
	localparam int OW = mdrp_pkg::DUTY_W;

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_DECODE    = 3'd1;
	localparam logic [2:0] S_ALU_WAIT  = 3'd2;
	localparam logic [2:0] S_STEPS_GO  = 3'd3;
	localparam logic [2:0] S_STEPS_WT  = 3'd4;
	localparam logic [2:0] S_INC_GO    = 3'd5;
	localparam logic [2:0] S_INC_WT    = 3'd6;
	localparam logic [2:0] S_FINISH    = 3'd7;

	mdrp_pkg::cfg_t                      cfg;
	mdrp_pkg::alu_ctl_t                  alu_ctl;
	logic [2:0]                          state_q;
	logic [mdrp_pkg::OP_W-1:0]           op_q;
	logic [mdrp_pkg::PHASE_W-1:0]        phase_q;
	logic [DB-1:0]                       duty_q;
	logic [mdrp_pkg::SECS_W-1:0]         secs_q;
	logic                                restart_q;
	logic [IW-1:0]                       inc_q [4];
	logic [mdrp_pkg::INC_IDX_W-1:0]      idx_q;
	logic [CW-1:0]                       steps_q;
	logic                                rsp_valid_q;
	logic [DB-1:0]                       rsp_duty_q;
	logic [mdrp_pkg::PHASE_W-1:0]        rsp_phase_q;
	logic                                rsp_restart_q;

	logic [DB-1:0]                       tgt_eff;
	logic [DB-1:0]                       alu_duty;
	logic [AW-1:0]                       alu_acc;
	logic                                alu_done;
	logic                                tick_add;
	logic                                tick_sub;
	logic                                up_blocked;
	logic [mdrp_pkg::INC_IDX_W-1:0]      inc_sel;
	logic [CW-1:0]                       time_sel;
	logic [CW-1:0]                       period_eff;
	logic                                div_start;
	logic [IW-1:0]                       div_dividend;
	logic [CW-1:0]                       div_divisor;
	logic [IW-1:0]                       div_q;
	logic                                div_done;
	logic [CW-1:0]                       steps_raw;

	mdrp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	mdrp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_q),
		.done     (div_done)
	);

	mdrp_alu u_alu (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (alu_ctl),
		.operand (inc_q[inc_sel]),
		.acc     (alu_acc),
		.done    (alu_done)
	);

	assign pready    = 1'b1;
	assign cmd.ready = (state_q == S_IDLE);

	assign rsp.valid         = rsp_valid_q;
	assign rsp.duty          = OW'(rsp_duty_q);
	assign rsp.phase         = rsp_phase_q;
	assign rsp.timer_restart = rsp_restart_q;

	// Target clipped to the duty range, integer duty from the accumulator
	always_comb begin
		tgt_eff  = (cfg.target_duty > CW'(mdrp_pkg::DUTY_MAX)) ?
			mdrp_pkg::DUTY_MAX : cfg.target_duty[DB-1:0];
		alu_duty = alu_acc[AW-1] ? mdrp_pkg::DUTY_MAX : alu_acc[AW-2:FB];
	end

	// Phase decode and increment select
	always_comb begin
		tick_add   = (phase_q == mdrp_pkg::PH_UP) || (phase_q == mdrp_pkg::PH_BOS_UP);
		tick_sub   = (phase_q == mdrp_pkg::PH_DOWN) || (phase_q == mdrp_pkg::PH_EOS_DOWN);
		up_blocked = duty_q > tgt_eff;
		unique case (phase_q)
			mdrp_pkg::PH_BOS_UP:   inc_sel = mdrp_pkg::INC_BOS;
			mdrp_pkg::PH_DOWN:     inc_sel = mdrp_pkg::INC_DOWN;
			mdrp_pkg::PH_EOS_DOWN: inc_sel = mdrp_pkg::INC_EOS;
			default:               inc_sel = mdrp_pkg::INC_UP;
		endcase
	end

	// Accumulator commands
	always_comb begin
		alu_ctl.start = (state_q == S_DECODE) && (op_q == mdrp_pkg::OP_TICK) &&
			((tick_add && !up_blocked) || tick_sub);
		alu_ctl.sub   = tick_sub;
		alu_ctl.clear = ((state_q == S_DECODE) && (op_q == mdrp_pkg::OP_STOP)) ||
			((state_q == S_INC_WT) && div_done && (idx_q == mdrp_pkg::INC_BOS));
	end

	// Divider operands: first steps = time / period, then increment = target / steps
	always_comb begin
		unique case (idx_q)
			mdrp_pkg::INC_UP:   time_sel = cfg.ramp_up_ms;
			mdrp_pkg::INC_DOWN: time_sel = cfg.ramp_down_ms;
			mdrp_pkg::INC_EOS:  time_sel = cfg.eos_down_ms;
			mdrp_pkg::INC_BOS:  time_sel = cfg.bos_up_ms;
		endcase
		period_eff   = (cfg.call_period_ms == '0) ? CW'(1) : cfg.call_period_ms;
		div_start    = (state_q == S_STEPS_GO) || (state_q == S_INC_GO);
		div_dividend = (state_q == S_STEPS_GO) ? IW'(time_sel) : {tgt_eff, {FB{1'b0}}};
		div_divisor  = (state_q == S_STEPS_GO) ? period_eff : steps_q;
		steps_raw    = div_q[CW-1:0];
	end

	// Command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			op_q          <= mdrp_pkg::OP_TICK;
			phase_q       <= mdrp_pkg::PH_WAIT;
			duty_q        <= '0;
			secs_q        <= '0;
			restart_q     <= 1'b0;
			idx_q         <= '0;
			steps_q       <= CW'(1);
			rsp_valid_q   <= 1'b0;
			rsp_duty_q    <= '0;
			rsp_phase_q   <= mdrp_pkg::PH_WAIT;
			rsp_restart_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				inc_q[i] <= '0;
			end
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						op_q      <= cmd.operation;
						restart_q <= 1'b0;
						if (cmd.second_passed && (secs_q != mdrp_pkg::SECS_MAX)) begin
							secs_q <= secs_q + 1'b1;
						end
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					state_q <= S_FINISH;
					unique case (op_q)
						mdrp_pkg::OP_TICK: begin
							if (tick_add) begin
								if (!up_blocked) begin
									state_q <= S_ALU_WAIT;
								end
							end else if (tick_sub) begin
								state_q <= S_ALU_WAIT;
							end else if ((phase_q == mdrp_pkg::PH_STEADY) &&
								!cfg.hold_steady && (secs_q >= cfg.steady_seconds)) begin
								phase_q   <= mdrp_pkg::PH_DOWN;
								restart_q <= 1'b1;
								secs_q    <= '0;
							end
						end
						mdrp_pkg::OP_START: begin
							idx_q   <= mdrp_pkg::INC_UP;
							state_q <= S_STEPS_GO;
						end
						mdrp_pkg::OP_STOP: begin
							phase_q <= mdrp_pkg::PH_OVER;
							duty_q  <= '0;
						end
						mdrp_pkg::OP_EOS: phase_q <= mdrp_pkg::PH_EOS_DOWN;
						mdrp_pkg::OP_BOS: phase_q <= mdrp_pkg::PH_BOS_UP;
						default: ;
					endcase
				end
				S_ALU_WAIT: begin
					if (alu_done) begin
						state_q <= S_FINISH;
						if (tick_add) begin
							// ramp up reaches the target: pin duty and go steady
							if (alu_duty >= tgt_eff) begin
								duty_q    <= tgt_eff;
								phase_q   <= mdrp_pkg::PH_STEADY;
								restart_q <= 1'b1;
								secs_q    <= '0;
							end else begin
								duty_q <= alu_duty;
							end
						end else begin
							duty_q <= alu_duty;
							if (alu_duty == '0) begin
								phase_q   <= (phase_q == mdrp_pkg::PH_DOWN) ?
									mdrp_pkg::PH_OVER : mdrp_pkg::PH_CONFIRM_STOP;
								restart_q <= 1'b1;
								secs_q    <= '0;
							end
						end
					end
				end
				S_STEPS_GO: state_q <= S_STEPS_WT;
				S_STEPS_WT: begin
					if (div_done) begin
						steps_q <= (steps_raw == '0) ? CW'(1) : steps_raw;
						state_q <= S_INC_GO;
					end
				end
				S_INC_GO: state_q <= S_INC_WT;
				S_INC_WT: begin
					if (div_done) begin
						inc_q[idx_q] <= div_q;
						if (idx_q == mdrp_pkg::INC_BOS) begin
							duty_q  <= '0;
							phase_q <= mdrp_pkg::PH_UP;
							state_q <= S_FINISH;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_STEPS_GO;
						end
					end
				end
				S_FINISH: begin
					// hand the beat to the output register once it is free
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q   <= 1'b1;
						rsp_duty_q    <= duty_q;
						rsp_phase_q   <= phase_q;
						rsp_restart_q <= restart_q;
						state_q       <= S_IDLE;
					end
				end
			endcase
		end
	end

	// Stopped phases always show zero duty
	a_stop_duty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && ((rsp.phase == mdrp_pkg::PH_OVER) ||
			(rsp.phase == mdrp_pkg::PH_CONFIRM_STOP)) |-> (rsp.duty == '0))
		else $error("nonzero duty in a stopped phase");

	// A timer restart only comes with a phase that a transition can enter
	a_restart_phase: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.timer_restart |->
			((rsp.phase == mdrp_pkg::PH_STEADY) || (rsp.phase == mdrp_pkg::PH_DOWN) ||
			(rsp.phase == mdrp_pkg::PH_OVER) || (rsp.phase == mdrp_pkg::PH_CONFIRM_STOP)))
		else $error("timer restart with an unexpected phase");

	// Accumulator completes only while the sequencer waits for it
	a_alu_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		alu_done |-> (state_q == S_ALU_WAIT))
		else $error("accumulator finished outside its wait state");

	// Divider completes only while the sequencer waits for it
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> ((state_q == S_STEPS_WT) || (state_q == S_INC_WT)))
		else $error("divider finished outside its wait states");

endmodule

// File: rtl/core/mdrp_regs.sv
// APB register bank holding the ramp profile configuration.
module mdrp_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mdrp_pkg::ADDR_W-1:0]   paddr,
	input  logic [mdrp_pkg::DATA_W-1:0]   pwdata,
	output logic [mdrp_pkg::DATA_W-1:0]   prdata,
	output mdrp_pkg::cfg_t                cfg
);

	localparam int DW = mdrp_pkg::DATA_W;

	logic [mdrp_pkg::REG_IDX_W-1:0] idx;
	logic                           wr_en;
	mdrp_pkg::cfg_t                 cfg_q;

	assign idx   = paddr[mdrp_pkg::ADDR_W-1:2];
	assign wr_en = psel & penable & pwrite;
	assign cfg   = cfg_q;

	// Register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q                <= '0;
			cfg_q.call_period_ms <= mdrp_pkg::CALL_PERIOD_RESET;
		end else if (wr_en) begin
			unique case (idx)
				mdrp_pkg::REG_TARGET:  cfg_q.target_duty    <= pwdata[mdrp_pkg::CFG_W-1:0];
				mdrp_pkg::REG_PERIOD:  cfg_q.call_period_ms <= pwdata[mdrp_pkg::CFG_W-1:0];
				mdrp_pkg::REG_RAMP_UP: cfg_q.ramp_up_ms     <= pwdata[mdrp_pkg::CFG_W-1:0];
				mdrp_pkg::REG_RAMP_DN: cfg_q.ramp_down_ms   <= pwdata[mdrp_pkg::CFG_W-1:0];
				mdrp_pkg::REG_BOS_UP:  cfg_q.bos_up_ms      <= pwdata[mdrp_pkg::CFG_W-1:0];
				mdrp_pkg::REG_EOS_DN:  cfg_q.eos_down_ms    <= pwdata[mdrp_pkg::CFG_W-1:0];
				mdrp_pkg::REG_STEADY:  cfg_q.steady_seconds <= pwdata[mdrp_pkg::SECS_W-1:0];
				mdrp_pkg::REG_FOREVER: cfg_q.hold_steady    <= pwdata[0];
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (idx)
			mdrp_pkg::REG_TARGET:  prdata = DW'(cfg_q.target_duty);
			mdrp_pkg::REG_PERIOD:  prdata = DW'(cfg_q.call_period_ms);
			mdrp_pkg::REG_RAMP_UP: prdata = DW'(cfg_q.ramp_up_ms);
			mdrp_pkg::REG_RAMP_DN: prdata = DW'(cfg_q.ramp_down_ms);
			mdrp_pkg::REG_BOS_UP:  prdata = DW'(cfg_q.bos_up_ms);
			mdrp_pkg::REG_EOS_DN:  prdata = DW'(cfg_q.eos_down_ms);
			mdrp_pkg::REG_STEADY:  prdata = DW'(cfg_q.steady_seconds);
			mdrp_pkg::REG_FOREVER: prdata = DW'(cfg_q.hold_steady);
		endcase
	end

endmodule

// File: rtl/core/mdrp_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module mdrp_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mdrp_pkg::INC_W-1:0]    dividend,
	input  logic [mdrp_pkg::CFG_W-1:0]    divisor,
	output logic [mdrp_pkg::INC_W-1:0]    quotient,
	output logic                          done
);

	localparam int QW = mdrp_pkg::INC_W;
	localparam int RW = mdrp_pkg::CFG_W;
	localparam logic [mdrp_pkg::DIV_CNT_W-1:0] LAST = mdrp_pkg::DIV_CNT_W'(QW - 1);

	logic [RW-1:0]                    rem_q;
	logic [QW-1:0]                    quo_q;
	logic [RW-1:0]                    dsr_q;
	logic [mdrp_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic                             busy_q;
	logic                             done_q;
	logic [RW:0]                      trial;
	logic                             fits;

	// Trial subtract of the divisor from the partial remainder
	assign trial    = {rem_q, quo_q[QW-1]} - {1'b0, dsr_q};
	assign fits     = ~trial[RW];
	assign quotient = quo_q;
	assign done     = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial[RW-1:0] : {rem_q[RW-2:0], quo_q[QW-1]};
			quo_q <= {quo_q[QW-2:0], fits};
		end
	end

endmodule

// File: rtl/core/mdrp_alu.sv
// Bit-serial saturating add/subtract on the fine duty accumulator.
module mdrp_alu (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mdrp_pkg::alu_ctl_t            ctl,
	input  logic [mdrp_pkg::INC_W-1:0]    operand,
	output logic [mdrp_pkg::ACC_W-1:0]    acc,
	output logic                          done
);

	localparam int AW = mdrp_pkg::ACC_W;
	localparam logic [mdrp_pkg::ACC_CNT_W-1:0] LAST = mdrp_pkg::ACC_CNT_W'(AW - 1);

	logic [AW-1:0]                    acc_q;
	logic [AW-1:0]                    opd_q;
	logic [mdrp_pkg::ACC_CNT_W-1:0]   cnt_q;
	logic                             busy_q;
	logic                             sub_q;
	logic                             carry_q;
	logic                             done_q;
	logic                             sum_bit;
	logic                             carry_nx;
	logic [AW-1:0]                    shifted;

	// One full-adder bit per cycle, LSB first
	assign sum_bit  = acc_q[0] ^ opd_q[0] ^ carry_q;
	assign carry_nx = (acc_q[0] & opd_q[0]) | (carry_q & (acc_q[0] ^ opd_q[0]));
	assign shifted  = {sum_bit, acc_q[AW-1:1]};
	assign acc      = acc_q;
	assign done     = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			sub_q   <= 1'b0;
			carry_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.clear) begin
				acc_q <= '0;
			end else if (ctl.start) begin
				busy_q  <= 1'b1;
				cnt_q   <= '0;
				sub_q   <= ctl.sub;
				carry_q <= ctl.sub;
			end else if (busy_q) begin
				cnt_q   <= cnt_q + 1'b1;
				carry_q <= carry_nx;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					// carry out on add saturates high, borrow on subtract clamps to zero
					if (!sub_q && carry_nx) begin
						acc_q <= '1;
					end else if (sub_q && !carry_nx) begin
						acc_q <= '0;
					end else begin
						acc_q <= shifted;
					end
				end else begin
					acc_q <= shifted;
				end
			end
		end
	end

	// Operand shift register, inverted for subtract
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			opd_q <= ctl.sub ? ~AW'(operand) : AW'(operand);
		end else if (busy_q) begin
			opd_q <= {1'b0, opd_q[AW-1:1]};
		end
	end

endmodule

// File: tb/sv/motor_duty_ramp_profile_test.sv
// Self-checking testbench for the duty ramp profile generator: directed strokes, random strokes.
module motor_duty_ramp_profile_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1250;
	localparam int HOLD_CYCLES  = 300;

	typedef struct {
		logic [mdrp_pkg::OP_W-1:0] op;
		logic                      sec;
	} ramp_cmd_t;

	typedef struct {
		logic [mdrp_pkg::DUTY_W-1:0]  duty;
		logic [mdrp_pkg::PHASE_W-1:0] phase;
		logic                         restart;
	} ramp_result_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [mdrp_pkg::ADDR_W-1:0]   paddr = '0;
	logic [mdrp_pkg::DATA_W-1:0]   pwdata = '0;
	logic [mdrp_pkg::DATA_W-1:0]   prdata;
	logic                          pready;

	mdrp_cmd_if cmd_ch();
	mdrp_rsp_if rsp_ch();

	motor_duty_ramp_profile dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// Register copy and profile state as the block should hold them
	mdrp_pkg::cfg_t                 shadow_cfg;
	logic [mdrp_pkg::PHASE_W-1:0]   prof_phase;
	logic [mdrp_pkg::ACC_W-1:0]     prof_acc;
	logic [mdrp_pkg::SECS_W-1:0]    prof_secs;
	logic [mdrp_pkg::INC_W-1:0]     prof_inc [4];
	logic [mdrp_pkg::DUTY_BITS-1:0] prof_duty;

	ramp_cmd_t    pending_cmds[$];
	ramp_result_t predicted_duty_q[$];

	int mismatches = 0;
	int items_queued = 0;
	int cmds_taken = 0;
	int results_seen = 0;
	int reg_writes = 0;
	int profiles = 0;
	int hold_ask = 0;
	int hold_taken = 0;
	int cmd_gap = 0;
	int rsp_stall = 0;
	int hold_left = 0;
	bit cmd_quiet = 1'b0;
	bit rsp_quiet = 1'b0;
	logic [7:0] phases_seen = '0;

	task automatic report_mismatch(string what);
		mismatches++;
		$display("[%0t] MISMATCH: %s", $time, what);
	endtask

	function automatic bit coin(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// Idle length: mostly none or short, a few long
	function automatic int pause_len(bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [mdrp_pkg::DUTY_BITS-1:0] capped_target();
		return (shadow_cfg.target_duty > mdrp_pkg::DUTY_MAX) ? mdrp_pkg::DUTY_MAX :
			shadow_cfg.target_duty[mdrp_pkg::DUTY_BITS-1:0];
	endfunction

	// Target in fixed point over max(1, span / period), truncated
	function automatic logic [mdrp_pkg::INC_W-1:0] ramp_step_size(
			logic [mdrp_pkg::CFG_W-1:0] span_ms);
		longint unsigned period, steps;
		period = (shadow_cfg.call_period_ms == 0) ? 1 : shadow_cfg.call_period_ms;
		steps = span_ms / period;
		if (steps == 0)
			steps = 1;
		return mdrp_pkg::INC_W'((64'(capped_target()) << mdrp_pkg::FRAC_BITS) / steps);
	endfunction

	function automatic logic [mdrp_pkg::DUTY_BITS-1:0] acc_whole();
		logic [mdrp_pkg::ACC_W-mdrp_pkg::FRAC_BITS-1:0] whole;
		whole = prof_acc[mdrp_pkg::ACC_W-1:mdrp_pkg::FRAC_BITS];
		return (whole > mdrp_pkg::DUTY_MAX) ? mdrp_pkg::DUTY_MAX :
			whole[mdrp_pkg::DUTY_BITS-1:0];
	endfunction

	// One up step; saturating add, stops at the target
	function automatic bit ramp_rise(logic [mdrp_pkg::INC_W-1:0] step);
		logic [mdrp_pkg::DUTY_BITS-1:0] goal;
		logic [mdrp_pkg::ACC_W:0]       sum;
		goal = capped_target();
		if (prof_duty > goal)
			return 1'b0;
		sum = prof_acc + step;
		prof_acc = sum[mdrp_pkg::ACC_W] ? {mdrp_pkg::ACC_W{1'b1}} : sum[mdrp_pkg::ACC_W-1:0];
		prof_duty = acc_whole();
		if (prof_duty >= goal) begin
			prof_duty = goal;
			prof_phase = mdrp_pkg::PH_STEADY;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// One down step; clamps at zero
	function automatic bit ramp_fall(logic [mdrp_pkg::INC_W-1:0] step,
			logic [mdrp_pkg::PHASE_W-1:0] next_phase);
		prof_acc = (prof_acc > step) ? prof_acc - step : mdrp_pkg::ACC_W'(0);
		prof_duty = acc_whole();
		if (prof_duty == 0) begin
			prof_phase = next_phase;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Apply one accepted command beat and queue the duty report it causes
	function automatic void advance_ramp(logic [mdrp_pkg::OP_W-1:0] op, logic sec);
		ramp_result_t r;
		bit           restart;
		restart = 1'b0;
		if (sec && prof_secs != mdrp_pkg::SECS_MAX)
			prof_secs++;
		case (op)
			mdrp_pkg::OP_TICK: begin
				case (prof_phase)
					mdrp_pkg::PH_UP:
						restart = ramp_rise(prof_inc[mdrp_pkg::INC_UP]);
					mdrp_pkg::PH_BOS_UP:
						restart = ramp_rise(prof_inc[mdrp_pkg::INC_BOS]);
					mdrp_pkg::PH_DOWN:
						restart = ramp_fall(prof_inc[mdrp_pkg::INC_DOWN], mdrp_pkg::PH_OVER);
					mdrp_pkg::PH_EOS_DOWN:
						restart = ramp_fall(prof_inc[mdrp_pkg::INC_EOS],
							mdrp_pkg::PH_CONFIRM_STOP);
					mdrp_pkg::PH_STEADY: begin
						if (!shadow_cfg.hold_steady &&
						    prof_secs >= shadow_cfg.steady_seconds) begin
							prof_phase = mdrp_pkg::PH_DOWN;
							restart = 1'b1;
						end
					end
					default: ;
				endcase
			end
			mdrp_pkg::OP_START: begin
				prof_inc[mdrp_pkg::INC_UP]   = ramp_step_size(shadow_cfg.ramp_up_ms);
				prof_inc[mdrp_pkg::INC_DOWN] = ramp_step_size(shadow_cfg.ramp_down_ms);
				prof_inc[mdrp_pkg::INC_EOS]  = ramp_step_size(shadow_cfg.eos_down_ms);
				prof_inc[mdrp_pkg::INC_BOS]  = ramp_step_size(shadow_cfg.bos_up_ms);
				prof_acc = '0;
				prof_duty = '0;
				prof_phase = mdrp_pkg::PH_UP;
			end
			mdrp_pkg::OP_STOP: begin
				prof_phase = mdrp_pkg::PH_OVER;
				prof_acc = '0;
				prof_duty = '0;
			end
			mdrp_pkg::OP_EOS: prof_phase = mdrp_pkg::PH_EOS_DOWN;
			mdrp_pkg::OP_BOS: prof_phase = mdrp_pkg::PH_BOS_UP;
			default: ;
		endcase
		if (restart)
			prof_secs = '0;
		r.duty = prof_duty;
		r.phase = prof_phase;
		r.restart = restart;
		predicted_duty_q.push_back(r);
	endfunction

	// Command driver
	always @(posedge clk or negedge arst_n) begin
		ramp_cmd_t next_cmd;
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.operation <= mdrp_pkg::OP_TICK;
			cmd_ch.second_passed <= 1'b0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				advance_ramp(cmd_ch.operation, cmd_ch.second_passed);
				cmds_taken++;
				if ($urandom_range(0, 49) == 0)
					cmd_quiet = !cmd_quiet;
			end
			if (cmd_ch.valid && !cmd_ch.ready) begin
				// beat still waiting for the block
			end else if (cmd_gap > 0) begin
				cmd_gap--;
				cmd_ch.valid <= 1'b0;
			end else if (pending_cmds.size() != 0) begin
				next_cmd = pending_cmds.pop_front();
				cmd_ch.operation <= next_cmd.op;
				cmd_ch.second_passed <= next_cmd.sec;
				cmd_ch.valid <= 1'b1;
				cmd_gap = pause_len(cmd_quiet);
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// Result monitor and output backpressure
	always @(posedge clk or negedge arst_n) begin
		ramp_result_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_seen++;
				phases_seen[rsp_ch.phase] = 1'b1;
				if (predicted_duty_q.size() == 0) begin
					report_mismatch($sformatf("unexpected beat: duty %0d phase %0d restart %0b",
						rsp_ch.duty, rsp_ch.phase, rsp_ch.timer_restart));
				end else begin
					want = predicted_duty_q.pop_front();
					if (rsp_ch.duty !== want.duty)
						report_mismatch($sformatf("beat %0d duty %0d, predicted %0d",
							results_seen, rsp_ch.duty, want.duty));
					if (rsp_ch.phase !== want.phase)
						report_mismatch($sformatf("beat %0d phase %0d, predicted %0d",
							results_seen, rsp_ch.phase, want.phase));
					if (rsp_ch.timer_restart !== want.restart)
						report_mismatch($sformatf("beat %0d timer_restart %0b, predicted %0b",
							results_seen, rsp_ch.timer_restart, want.restart));
				end
				rsp_stall = pause_len(rsp_quiet);
				if ($urandom_range(0, 49) == 0)
					rsp_quiet = !rsp_quiet;
			end else if (rsp_stall == 0 && !rsp_quiet && $urandom_range(0, 31) == 0) begin
				rsp_stall = $urandom_range(1, 6);
			end
			if (hold_taken != hold_ask) begin
				hold_taken = hold_ask;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (rsp_stall > 0) begin
				rsp_stall--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic queue_cmd(logic [mdrp_pkg::OP_W-1:0] op, logic sec);
		ramp_cmd_t c;
		c.op = op;
		c.sec = sec;
		pending_cmds.push_back(c);
		items_queued++;
	endtask

	// Ticks with the odd stray command mixed in
	task automatic queue_ticks(int n, int sec_pct);
		repeat (n) begin
			if (coin(8))
				queue_cmd(mdrp_pkg::OP_W'($urandom_range(0, 7)), coin(sec_pct));
			else
				queue_cmd(mdrp_pkg::OP_TICK, coin(sec_pct));
		end
	endtask

	function automatic int ramp_ticks(logic [mdrp_pkg::CFG_W-1:0] span_ms);
		int unsigned p, n;
		p = (shadow_cfg.call_period_ms == 0) ? 1 : shadow_cfg.call_period_ms;
		n = span_ms / p;
		if (n == 0)
			n = 1;
		n += $urandom_range(0, 2);
		return (n > 40) ? 40 : n;
	endfunction

	// One stroke: start, ramp up, then either a normal stop or an end-of-stroke turn
	task automatic queue_stroke();
		int dwell;
		dwell = (shadow_cfg.steady_seconds <= 8) ? shadow_cfg.steady_seconds + 2 : 6;
		queue_cmd(mdrp_pkg::OP_START, coin(20));
		queue_ticks(ramp_ticks(shadow_cfg.ramp_up_ms), 25);
		if (coin(50)) begin
			queue_ticks(dwell, 85);
			queue_ticks(ramp_ticks(shadow_cfg.ramp_down_ms), 25);
		end else begin
			queue_ticks($urandom_range(0, 3), 50);
			queue_cmd(mdrp_pkg::OP_EOS, coin(30));
			queue_ticks(ramp_ticks(shadow_cfg.eos_down_ms), 25);
			queue_cmd(mdrp_pkg::OP_BOS, coin(30));
			queue_ticks(ramp_ticks(shadow_cfg.bos_up_ms), 25);
			queue_ticks($urandom_range(0, 3), 60);
		end
		if (coin(40))
			queue_cmd(mdrp_pkg::OP_STOP, coin(30));
	endtask

	// Setup and access phase; read data is taken during access
	task automatic apb_cycle(logic [mdrp_pkg::REG_IDX_W-1:0] idx, logic wr,
			logic [mdrp_pkg::DATA_W-1:0] wdata, output logic [mdrp_pkg::DATA_W-1:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= mdrp_pkg::ADDR_W'({idx, 2'b00});
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		rdata = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write, mirror, read back
	task automatic write_reg(logic [mdrp_pkg::REG_IDX_W-1:0] idx,
			logic [mdrp_pkg::DATA_W-1:0] value);
		logic [mdrp_pkg::DATA_W-1:0] readback, stored;
		apb_cycle(idx, 1'b1, value, readback);
		stored = mdrp_pkg::DATA_W'(value[mdrp_pkg::CFG_W-1:0]);
		case (idx)
			mdrp_pkg::REG_TARGET:  shadow_cfg.target_duty = value[mdrp_pkg::CFG_W-1:0];
			mdrp_pkg::REG_PERIOD:  shadow_cfg.call_period_ms = value[mdrp_pkg::CFG_W-1:0];
			mdrp_pkg::REG_RAMP_UP: shadow_cfg.ramp_up_ms = value[mdrp_pkg::CFG_W-1:0];
			mdrp_pkg::REG_RAMP_DN: shadow_cfg.ramp_down_ms = value[mdrp_pkg::CFG_W-1:0];
			mdrp_pkg::REG_BOS_UP:  shadow_cfg.bos_up_ms = value[mdrp_pkg::CFG_W-1:0];
			mdrp_pkg::REG_EOS_DN:  shadow_cfg.eos_down_ms = value[mdrp_pkg::CFG_W-1:0];
			mdrp_pkg::REG_STEADY: begin
				shadow_cfg.steady_seconds = value[mdrp_pkg::SECS_W-1:0];
				stored = mdrp_pkg::DATA_W'(value[mdrp_pkg::SECS_W-1:0]);
			end
			mdrp_pkg::REG_FOREVER: begin
				shadow_cfg.hold_steady = value[0];
				stored = mdrp_pkg::DATA_W'(value[0]);
			end
			default: ;
		endcase
		reg_writes++;
		apb_cycle(idx, 1'b0, '0, readback);
		if (readback !== stored)
			report_mismatch($sformatf("register %0d reads %0h, written %0h", idx, readback, stored));
	endtask

	function automatic logic [mdrp_pkg::CFG_W-1:0] pick_span();
		int unsigned p, v;
		if (coin(10))
			return coin(50) ? mdrp_pkg::CFG_W'(0) : mdrp_pkg::CFG_W'(16'hFFFF);
		p = (shadow_cfg.call_period_ms == 0) ? 1 : shadow_cfg.call_period_ms;
		v = p * $urandom_range(0, 20) + $urandom_range(0, p - 1);
		return (v > 65535) ? mdrp_pkg::CFG_W'(16'hFFFF) : mdrp_pkg::CFG_W'(v);
	endfunction

	// New random setting of every register, extremes now and then
	task automatic load_profile();
		if (coin(10))
			write_reg(mdrp_pkg::REG_TARGET, coin(50) ? 0 : 16'hFFFF);
		else
			write_reg(mdrp_pkg::REG_TARGET, $urandom_range(1, 65535));
		if (coin(10))
			write_reg(mdrp_pkg::REG_PERIOD, coin(50) ? 0 : 16'hFFFF);
		else
			write_reg(mdrp_pkg::REG_PERIOD, $urandom_range(1, 400));
		write_reg(mdrp_pkg::REG_RAMP_UP, mdrp_pkg::DATA_W'(pick_span()));
		write_reg(mdrp_pkg::REG_RAMP_DN, mdrp_pkg::DATA_W'(pick_span()));
		write_reg(mdrp_pkg::REG_BOS_UP, mdrp_pkg::DATA_W'(pick_span()));
		write_reg(mdrp_pkg::REG_EOS_DN, mdrp_pkg::DATA_W'(pick_span()));
		if (coin(10))
			write_reg(mdrp_pkg::REG_STEADY, coin(50) ? 0 : 15'h7FFF);
		else
			write_reg(mdrp_pkg::REG_STEADY, $urandom_range(0, 4));
		write_reg(mdrp_pkg::REG_FOREVER, mdrp_pkg::DATA_W'(coin(20)));
		profiles++;
	endtask

	// Sender holds back until the block has answered everything
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_cmds.size() != 0 || cmd_ch.valid || predicted_duty_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int directed_end;
		int waited;
		shadow_cfg = '0;
		shadow_cfg.call_period_ms = mdrp_pkg::CALL_PERIOD_RESET;
		prof_phase = mdrp_pkg::PH_WAIT;
		prof_acc = '0;
		prof_secs = '0;
		prof_duty = '0;
		foreach (prof_inc[i])
			prof_inc[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Full target, zero period, ramps of one to three steps: duty saturation and exact zero landings
		write_reg(mdrp_pkg::REG_TARGET, 16'hFFFF);
		write_reg(mdrp_pkg::REG_PERIOD, 0);
		write_reg(mdrp_pkg::REG_RAMP_UP, 0);
		write_reg(mdrp_pkg::REG_RAMP_DN, 3);
		write_reg(mdrp_pkg::REG_BOS_UP, 2);
		write_reg(mdrp_pkg::REG_EOS_DN, 1);
		write_reg(mdrp_pkg::REG_STEADY, 1);
		write_reg(mdrp_pkg::REG_FOREVER, 0);
		queue_cmd(mdrp_pkg::OP_TICK, 1'b1);
		queue_cmd(mdrp_pkg::OP_W'(5), 1'b0);
		queue_cmd(mdrp_pkg::OP_W'(6), 1'b1);
		queue_cmd(mdrp_pkg::OP_W'(7), 1'b1);
		queue_cmd(mdrp_pkg::OP_START, 1'b0);
		queue_cmd(mdrp_pkg::OP_TICK, 1'b0);
		queue_cmd(mdrp_pkg::OP_TICK, 1'b1);
		queue_ticks(0, 0);
		repeat (3) queue_cmd(mdrp_pkg::OP_TICK, 1'b0);
		queue_cmd(mdrp_pkg::OP_EOS, 1'b0);
		queue_cmd(mdrp_pkg::OP_TICK, 1'b0);
		queue_cmd(mdrp_pkg::OP_BOS, 1'b1);
		queue_cmd(mdrp_pkg::OP_TICK, 1'b0);
		queue_cmd(mdrp_pkg::OP_TICK, 1'b0);
		queue_cmd(mdrp_pkg::OP_EOS, 1'b0);
		queue_cmd(mdrp_pkg::OP_TICK, 1'b0);
		queue_cmd(mdrp_pkg::OP_STOP, 1'b0);
		wait_idle();

		// Target lowered under a running ramp: up ticks must hold
		write_reg(mdrp_pkg::REG_TARGET, 1000);
		write_reg(mdrp_pkg::REG_PERIOD, 200);
		write_reg(mdrp_pkg::REG_RAMP_UP, 2000);
		write_reg(mdrp_pkg::REG_FOREVER, 1);
		queue_cmd(mdrp_pkg::OP_START, 1'b0);
		queue_cmd(mdrp_pkg::OP_TICK, 1'b0);
		queue_cmd(mdrp_pkg::OP_TICK, 1'b1);
		wait_idle();
		write_reg(mdrp_pkg::REG_TARGET, 100);
		queue_cmd(mdrp_pkg::OP_TICK, 1'b0);
		wait_idle();

		// Zero increments from a zero target at start, then a live target raise
		write_reg(mdrp_pkg::REG_TARGET, 0);
		queue_cmd(mdrp_pkg::OP_START, 1'b0);
		wait_idle();
		write_reg(mdrp_pkg::REG_TARGET, 50);
		queue_cmd(mdrp_pkg::OP_BOS, 1'b0);
		queue_cmd(mdrp_pkg::OP_TICK, 1'b0);
		directed_end = items_queued;

		// Random strokes under random settings
		while (items_queued < directed_end + RANDOM_ITEMS) begin
			wait_idle();
			load_profile();
			if (coin(25)) begin
				queue_cmd(mdrp_pkg::OP_START, coin(20));
				queue_ticks($urandom_range(1, 4), 20);
				wait_idle();
				write_reg(mdrp_pkg::REG_TARGET, $urandom_range(0, shadow_cfg.target_duty));
				queue_ticks(ramp_ticks(shadow_cfg.ramp_up_ms), 20);
			end
			repeat ($urandom_range(2, 5)) begin
				if (coin(20))
					queue_ticks($urandom_range(5, 15), 50);
				else
					queue_stroke();
			end
			// long output stall while commands keep coming
			if (profiles == 1)
				hold_ask++;
		end

		do @(negedge clk); while (pending_cmds.size() != 0 || cmd_ch.valid);
		waited = 0;
		while (predicted_duty_q.size() != 0 && waited < 20000) begin
			@(negedge clk);
			waited++;
		end
		repeat (300) @(posedge clk);
		if (predicted_duty_q.size() != 0)
			report_mismatch($sformatf("%0d duty reports never arrived", predicted_duty_q.size()));

		$display("Ran %0d commands, %0d duty reports, %0d register writes over %0d settings.",
			cmds_taken, results_seen, reg_writes, profiles);
		$display("Phases reported (bit per phase): %b; long output stalls: %0d.",
			phases_seen, hold_taken);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#(30_000_000);
		$display("Simulation FAILED");
		$finish;
	end

endmodule
